FILE: rtl/core/hrrn_pkg.sv
// ----------------------------------------------------------------------------
// hrrn_pkg: shared codes and constants of the job dispatcher
// Item modes and result kinds used on the request and response words.
// ----------------------------------------------------------------------------
package hrrn_pkg;

   localparam logic [1:0] MODE_LOAD     = 2'd0;
   localparam logic [1:0] MODE_DISPATCH = 2'd1;
   localparam logic [1:0] MODE_COMPLETE = 2'd2;

   localparam logic [2:0] KIND_LOADED     = 3'd0;
   localparam logic [2:0] KIND_FULL       = 3'd1;
   localparam logic [2:0] KIND_DISPATCHED = 3'd2;
   localparam logic [2:0] KIND_NONE_DISP  = 3'd3;
   localparam logic [2:0] KIND_COMPLETED  = 3'd4;
   localparam logic [2:0] KIND_NONE_RUN   = 3'd5;

   localparam logic [1:0] CSR_RAM   = 2'd0;
   localparam logic [1:0] CSR_TAPE  = 2'd1;
   localparam logic [1:0] CSR_PRINT = 2'd2;

   localparam int MAX_ADMIT = 16;

endpackage

FILE: rtl/core/hrrn_job_dispatcher.sv
// ----------------------------------------------------------------------------
// hrrn_job_dispatcher: highest response ratio next job table
// Load, dispatch and complete jobs in a slot table with one shared
// slot-scan sequencer and one shared cross-multiply compare.
// ----------------------------------------------------------------------------
// Sequencing: load writes the lowest free slot; complete makes one scan pass and
// one update pass over the slots; dispatch makes one compare scan over the slots
// per admitted job plus one failing scan (none after the 16th), then sends the
// closing word. Each dispatched word is held until the next scan shows whether
// it is the last. One item at a time: a new request is taken only in idle.
// Output stalls hold the sequencer.
// Reset: synchronous; clears slot valid/running bits, usage, clock, counter
// and restores the capacity registers to 64 memory, 4 tapes, 2 printers.
module hrrn_job_dispatcher #(
   parameter int JOB_SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [7:0]  req_job_id,
   input  logic [7:0]  req_job_size,
   input  logic [3:0]  req_tape_needs,
   input  logic [3:0]  req_print_needs,
   input  logic [15:0] req_run_length,
   input  logic [15:0] req_waited_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_job_out,
   output logic [31:0] rsp_time_now,
   output logic        rsp_last,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);

   localparam int IW = (JOB_SLOTS > 1) ? $clog2(JOB_SLOTS) : 1;
   localparam int CW = $clog2(JOB_SLOTS + 1);
   localparam int AW = $clog2(hrrn_pkg::MAX_ADMIT + 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_LOAD, ST_DSCAN, ST_DCMP, ST_DDONE,
      ST_CSCAN, ST_CUPD, ST_OUT
   } state_type;

   state_type   state_ff;
   logic [7:0]  ram_cap_ff;
   logic [3:0]  tape_cap_ff, print_cap_ff;
   logic [8:0]  ram_used_ff;
   logic [4:0]  tape_used_ff, print_used_ff;
   logic [31:0] clock_ff;
   logic [15:0] order_ff;
   logic [JOB_SLOTS-1:0] valid_ff, run_ff;

   logic [7:0]  sjob_ff   [JOB_SLOTS];
   logic [7:0]  ssize_ff  [JOB_SLOTS];
   logic [3:0]  stape_ff  [JOB_SLOTS];
   logic [3:0]  sprint_ff [JOB_SLOTS];
   logic [15:0] srem_ff   [JOB_SLOTS];
   logic [31:0] swait_ff  [JOB_SLOTS];
   logic [15:0] sord_ff   [JOB_SLOTS];

   // request latch
   logic [7:0]  id_ff, size_ff;
   logic [3:0]  tneed_ff, pneed_ff;
   logic [15:0] run_len_ff, wait_in_ff;

   // scan state
   logic [CW-1:0] idx_ff;
   logic          has_best_ff;
   logic [IW-1:0] best_ff;
   logic [AW-1:0] admit_ff;
   logic [15:0]   tdelta_ff;
   logic          gt_ab_ff, gt_ba_ff;

   // pending result, moved to the response word when the output frees
   logic [2:0]  pkind_ff;
   logic [7:0]  pjob_ff;

   logic        rv_ff, rlast_ff;
   logic [2:0]  rkind_ff;
   logic [7:0]  rjob_ff;
   logic [31:0] rtime_ff;

   assign req_stall    = (state_ff != ST_IDLE);
   assign rsp_valid    = rv_ff;
   assign rsp_kind     = rkind_ff;
   assign rsp_job_out  = rjob_ff;
   assign rsp_time_now = rtime_ff;
   assign rsp_last     = rlast_ff;

   wire [IW-1:0] ci = idx_ff[IW-1:0];

   // output register free this cycle, and a new word loaded into it
   wire out_free = !rv_ff || !rsp_stall;
   wire rsp_load = out_free && ((state_ff == ST_OUT) ||
                   ((state_ff == ST_DDONE) && has_best_ff && (admit_ff != '0)));

   // free resources, floored at zero
   wire [8:0] free_ram = ({1'b0, ram_cap_ff} > ram_used_ff) ?
                         ({1'b0, ram_cap_ff} - ram_used_ff) : 9'd0;
   wire [4:0] free_tp  = ({1'b0, tape_cap_ff} > tape_used_ff) ?
                         ({1'b0, tape_cap_ff} - tape_used_ff) : 5'd0;
   wire [4:0] free_pr  = ({1'b0, print_cap_ff} > print_used_ff) ?
                         ({1'b0, print_cap_ff} - print_used_ff) : 5'd0;

   wire cand_wait = valid_ff[ci] && !run_ff[ci] &&
                    ({1'b0, ssize_ff[ci]} <= free_ram) &&
                    ({1'b0, stape_ff[ci]} <= free_tp) &&
                    ({1'b0, sprint_ff[ci]} <= free_pr);

   // shared cross-multiply: (w+r)*r' for both orders, 33x16 each
   wire [32:0] num_c = {1'b0, swait_ff[ci]} + {17'd0, srem_ff[ci]};
   wire [32:0] num_b = {1'b0, swait_ff[best_ff]} + {17'd0, srem_ff[best_ff]};
   wire [48:0] prod_c = num_c * srem_ff[best_ff];
   wire [48:0] prod_b = num_b * srem_ff[ci];

   // complete scan compare
   wire cand_run = valid_ff[ci] && run_ff[ci];
   wire run_better = !has_best_ff || (srem_ff[ci] < srem_ff[best_ff]) ||
                     ((srem_ff[ci] == srem_ff[best_ff]) &&
                      (sord_ff[ci] > sord_ff[best_ff]));

   // lowest free slot
   logic          free_found;
   logic [IW-1:0] free_idx;
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = JOB_SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IW'(i);
         end
      end
   end

   wire [32:0] clk_sum = {1'b0, clock_ff} + {17'd0, tdelta_ff};

   // sequencer, table and response word
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ram_cap_ff    <= 8'd64;
         tape_cap_ff   <= 4'd4;
         print_cap_ff  <= 4'd2;
         ram_used_ff   <= '0;
         tape_used_ff  <= '0;
         print_used_ff <= '0;
         clock_ff      <= '0;
         order_ff      <= '0;
         valid_ff      <= '0;
         run_ff        <= '0;
         rv_ff         <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               hrrn_pkg::CSR_RAM:   ram_cap_ff   <= csr_data;
               hrrn_pkg::CSR_TAPE:  tape_cap_ff  <= csr_data[3:0];
               hrrn_pkg::CSR_PRINT: print_cap_ff <= csr_data[3:0];
               default: ;
            endcase
         end
         // raise the response word when one is loaded, drop it once taken
         if (rsp_load) rv_ff <= 1'b1;
         else if (rv_ff && !rsp_stall) rv_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  id_ff       <= req_job_id;
                  size_ff     <= req_job_size;
                  tneed_ff    <= req_tape_needs;
                  pneed_ff    <= req_print_needs;
                  run_len_ff  <= req_run_length;
                  wait_in_ff  <= req_waited_in;
                  idx_ff      <= '0;
                  has_best_ff <= 1'b0;
                  best_ff     <= '0;
                  admit_ff    <= '0;
                  case (req_mode)
                     hrrn_pkg::MODE_LOAD:     state_ff <= ST_LOAD;
                     hrrn_pkg::MODE_DISPATCH: state_ff <= ST_DSCAN;
                     hrrn_pkg::MODE_COMPLETE: state_ff <= ST_CSCAN;
                     default:                 state_ff <= ST_IDLE;
                  endcase
               end
            end
            ST_LOAD: begin
               if (free_found) begin
                  valid_ff[free_idx]  <= 1'b1;
                  run_ff[free_idx]    <= 1'b0;
                  sjob_ff[free_idx]   <= id_ff;
                  ssize_ff[free_idx]  <= size_ff;
                  stape_ff[free_idx]  <= tneed_ff;
                  sprint_ff[free_idx] <= pneed_ff;
                  srem_ff[free_idx]   <= (run_len_ff == 16'd0) ? 16'd1 : run_len_ff;
                  swait_ff[free_idx]  <= {16'd0, wait_in_ff};
                  sord_ff[free_idx]   <= order_ff;
                  order_ff            <= order_ff + 16'd1;
                  pkind_ff <= hrrn_pkg::KIND_LOADED;
               end else begin
                  pkind_ff <= hrrn_pkg::KIND_FULL;
               end
               pjob_ff  <= id_ff;
               state_ff <= ST_OUT;
            end
            // compare the two products for the current slot
            ST_DSCAN: begin
               if (idx_ff == CW'(JOB_SLOTS)) begin
                  state_ff <= ST_DDONE;
               end else begin
                  gt_ab_ff <= prod_c > prod_b;
                  gt_ba_ff <= prod_b > prod_c;
                  state_ff <= ST_DCMP;
               end
            end
            // keep the best candidate and advance
            ST_DCMP: begin
               if (cand_wait && (!has_best_ff || gt_ab_ff ||
                   (!gt_ba_ff && sord_ff[ci] < sord_ff[best_ff]))) begin
                  has_best_ff <= 1'b1;
                  best_ff     <= ci;
               end
               idx_ff   <= idx_ff + CW'(1);
               state_ff <= ST_DSCAN;
            end
            // admit the winner; the held word goes out once another follows
            ST_DDONE: begin
               if (has_best_ff) begin
                  if (admit_ff == '0 || out_free) begin
                     if (admit_ff != '0) begin
                        rkind_ff <= pkind_ff;
                        rjob_ff  <= pjob_ff;
                        rlast_ff <= 1'b0;
                        rtime_ff <= clock_ff;
                     end
                     run_ff[best_ff] <= 1'b1;
                     sord_ff[best_ff] <= order_ff;
                     order_ff      <= order_ff + 16'd1;
                     ram_used_ff   <= ram_used_ff + {1'b0, ssize_ff[best_ff]};
                     tape_used_ff  <= tape_used_ff + {1'b0, stape_ff[best_ff]};
                     print_used_ff <= print_used_ff + {1'b0, sprint_ff[best_ff]};
                     pkind_ff <= hrrn_pkg::KIND_DISPATCHED;
                     pjob_ff  <= sjob_ff[best_ff];
                     admit_ff <= admit_ff + AW'(1);
                     idx_ff      <= '0;
                     has_best_ff <= 1'b0;
                     if (admit_ff == AW'(hrrn_pkg::MAX_ADMIT - 1)) begin
                        state_ff <= ST_OUT;
                     end else begin
                        state_ff <= ST_DSCAN;
                     end
                  end
               end else begin
                  if (admit_ff == '0) begin
                     pkind_ff <= hrrn_pkg::KIND_NONE_DISP;
                     pjob_ff  <= '0;
                  end
                  state_ff <= ST_OUT;
               end
            end
            ST_CSCAN: begin
               if (idx_ff == CW'(JOB_SLOTS)) begin
                  if (has_best_ff) begin
                     tdelta_ff <= srem_ff[best_ff];
                     valid_ff[best_ff] <= 1'b0;
                     run_ff[best_ff]   <= 1'b0;
                     ram_used_ff  <= (ram_used_ff > {1'b0, ssize_ff[best_ff]}) ?
                        ram_used_ff - {1'b0, ssize_ff[best_ff]} : 9'd0;
                     tape_used_ff <= (tape_used_ff > {1'b0, stape_ff[best_ff]}) ?
                        tape_used_ff - {1'b0, stape_ff[best_ff]} : 5'd0;
                     print_used_ff <= (print_used_ff > {1'b0, sprint_ff[best_ff]}) ?
                        print_used_ff - {1'b0, sprint_ff[best_ff]} : 5'd0;
                     pkind_ff <= hrrn_pkg::KIND_COMPLETED;
                     pjob_ff  <= sjob_ff[best_ff];
                     idx_ff   <= '0;
                     state_ff <= ST_CUPD;
                  end else begin
                     pkind_ff <= hrrn_pkg::KIND_NONE_RUN;
                     pjob_ff  <= '0;
                     state_ff <= ST_OUT;
                  end
               end else begin
                  if (cand_run && run_better) begin
                     has_best_ff <= 1'b1;
                     best_ff     <= ci;
                  end
                  idx_ff <= idx_ff + CW'(1);
               end
            end
            // age every remaining slot, one per cycle
            ST_CUPD: begin
               if (idx_ff == CW'(JOB_SLOTS)) begin
                  clock_ff <= clk_sum[32] ? 32'hFFFF_FFFF : clk_sum[31:0];
                  state_ff <= ST_OUT;
               end else begin
                  if (valid_ff[ci]) begin
                     swait_ff[ci] <= ({1'b0, swait_ff[ci]} + {17'd0, tdelta_ff} >
                                     33'h0_FFFF_FFFF) ? 32'hFFFF_FFFF :
                                     swait_ff[ci] + {16'd0, tdelta_ff};
                     if (run_ff[ci])
                        srem_ff[ci] <= (srem_ff[ci] > tdelta_ff) ?
                                       srem_ff[ci] - tdelta_ff : 16'd0;
                  end
                  idx_ff <= idx_ff + CW'(1);
               end
            end
            // send the closing word of the item
            ST_OUT: begin
               if (out_free) begin
                  rkind_ff <= pkind_ff;
                  rjob_ff  <= pjob_ff;
                  rlast_ff <= 1'b1;
                  rtime_ff <= clock_ff;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: job dispatcher testbench
// Drives load, dispatch and complete words under random gaps and output
// stalls, predicts each response word from a local job table model and
// compares every field in order. Capacity registers change between phases.
// ----------------------------------------------------------------------------
module tb;

   localparam int SLOTS    = 16;
   localparam int WDOG_MAX = 20000;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]  mode;
      logic [7:0]  job_id;
      logic [7:0]  job_size;
      logic [3:0]  tape_needs;
      logic [3:0]  print_needs;
      logic [15:0] run_length;
      logic [15:0] waited_in;
   } job_req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  job_out;
      logic [31:0] time_now;
      logic        last;
   } job_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_mode = '0;
   logic [7:0]  req_job_id = '0;
   logic [7:0]  req_job_size = '0;
   logic [3:0]  req_tape_needs = '0;
   logic [3:0]  req_print_needs = '0;
   logic [15:0] req_run_length = '0;
   logic [15:0] req_waited_in = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_kind;
   logic [7:0]  rsp_job_out;
   logic [31:0] rsp_time_now;
   logic        rsp_last;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [7:0]  csr_data = '0;

   hrrn_job_dispatcher #(.JOB_SLOTS(SLOTS)) u_top (.*);

   always #5 clock = ~clock;

   // job table prediction state
   logic [7:0]  cap_ram;
   logic [3:0]  cap_tape, cap_print;
   logic        t_valid [SLOTS];
   logic        t_run   [SLOTS];
   logic [7:0]  t_job   [SLOTS];
   logic [7:0]  t_size  [SLOTS];
   logic [3:0]  t_tape  [SLOTS];
   logic [3:0]  t_print [SLOTS];
   logic [15:0] t_rem   [SLOTS];
   logic [31:0] t_wait  [SLOTS];
   logic [15:0] t_ord   [SLOTS];
   logic [8:0]  used_ram;
   logic [4:0]  used_tape, used_print;
   logic [31:0] now_clk;
   logic [15:0] ord_cnt;

   job_req_type pending_words[$];
   job_rsp_type expected_rsp[$];
   int       fail_count = 0;
   int       rsp_seen = 0;
   int       words_sent = 0;
   int       n_dispatched = 0, n_completed = 0, n_full = 0;
   bit       send_hold = 1'b0;
   bit       stim_done = 1'b0;

   function automatic logic [31:0] sat32(logic [31:0] a, logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   function automatic logic [31:0] free_units(logic [31:0] cap, logic [31:0] used);
      return cap > used ? cap - used : 32'd0;
   endfunction

   // strictly higher response ratio, exact by cross-multiplication
   function automatic bit ratio_higher(int a, int b);
      logic [63:0] na, nb;
      na = {32'd0, t_wait[a]} + t_rem[a];
      nb = {32'd0, t_wait[b]} + t_rem[b];
      return na * t_rem[b] > nb * t_rem[a];
   endfunction

   task automatic push_rsp(logic [2:0] kind, logic [7:0] job);
      expected_rsp.push_back('{kind, job, now_clk, 1'b0});
   endtask

   task automatic table_reset();
      cap_ram = 8'd64; cap_tape = 4'd4; cap_print = 4'd2;
      for (int i = 0; i < SLOTS; i++) begin
         t_valid[i] = 0; t_run[i] = 0;
      end
      used_ram = 0; used_tape = 0; used_print = 0;
      now_clk = 0; ord_cnt = 0;
   endtask

   // predict the response words of one accepted request word
   task automatic predict_word(job_req_type w);
      int best, n, slot;
      logic [31:0] fr, ft, fp, dt;
      n = 0;
      slot = -1;
      case (w.mode)
         hrrn_pkg::MODE_LOAD: begin
            for (int i = SLOTS - 1; i >= 0; i--)
               if (!t_valid[i]) slot = i;
            if (slot < 0) begin
               push_rsp(hrrn_pkg::KIND_FULL, w.job_id);
            end else begin
               t_valid[slot] = 1; t_run[slot] = 0;
               t_job[slot] = w.job_id; t_size[slot] = w.job_size;
               t_tape[slot] = w.tape_needs; t_print[slot] = w.print_needs;
               t_rem[slot] = (w.run_length == 0) ? 16'd1 : w.run_length;
               t_wait[slot] = {16'd0, w.waited_in};
               t_ord[slot] = ord_cnt; ord_cnt++;
               push_rsp(hrrn_pkg::KIND_LOADED, w.job_id);
            end
            n = 1;
         end
         hrrn_pkg::MODE_DISPATCH: begin
            while (n < hrrn_pkg::MAX_ADMIT) begin
               fr = free_units(cap_ram, used_ram);
               ft = free_units(cap_tape, used_tape);
               fp = free_units(cap_print, used_print);
               best = -1;
               for (int i = 0; i < SLOTS; i++) begin
                  if (!t_valid[i] || t_run[i]) continue;
                  if (t_size[i] > fr || t_tape[i] > ft || t_print[i] > fp) continue;
                  if (best < 0 || ratio_higher(i, best) ||
                      (!ratio_higher(best, i) && t_ord[i] < t_ord[best]))
                     best = i;
               end
               if (best < 0) break;
               t_run[best] = 1;
               t_ord[best] = ord_cnt; ord_cnt++;
               used_ram += t_size[best];
               used_tape += t_tape[best];
               used_print += t_print[best];
               push_rsp(hrrn_pkg::KIND_DISPATCHED, t_job[best]);
               n_dispatched++;
               n++;
            end
            if (n == 0) begin
               push_rsp(hrrn_pkg::KIND_NONE_DISP, 8'd0);
               n = 1;
            end
         end
         hrrn_pkg::MODE_COMPLETE: begin
            best = -1;
            for (int i = 0; i < SLOTS; i++) begin
               if (!t_valid[i] || !t_run[i]) continue;
               if (best < 0 || t_rem[i] < t_rem[best] ||
                   (t_rem[i] == t_rem[best] && t_ord[i] > t_ord[best]))
                  best = i;
            end
            if (best < 0) begin
               push_rsp(hrrn_pkg::KIND_NONE_RUN, 8'd0);
            end else begin
               dt = {16'd0, t_rem[best]};
               t_valid[best] = 0; t_run[best] = 0;
               used_ram = used_ram > t_size[best] ? used_ram - t_size[best] : 9'd0;
               used_tape = used_tape > t_tape[best] ? used_tape - t_tape[best] : 5'd0;
               used_print = used_print > t_print[best] ? used_print - t_print[best] : 5'd0;
               now_clk = sat32(now_clk, dt);
               for (int i = 0; i < SLOTS; i++) begin
                  if (!t_valid[i]) continue;
                  t_wait[i] = sat32(t_wait[i], dt);
                  if (t_run[i]) t_rem[i] = t_rem[i] > dt[15:0] ? t_rem[i] - dt[15:0] : 16'd0;
               end
               push_rsp(hrrn_pkg::KIND_COMPLETED, t_job[best]);
               n_completed++;
            end
            n = 1;
         end
         default: ;
      endcase
      if (n > 0) expected_rsp[$].last = 1'b1;
   endtask

   // drive request words in bursts with random gaps
   int burst_left = 0, gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_stall) begin
         predict_word({req_mode, req_job_id, req_job_size, req_tape_needs,
                       req_print_needs, req_run_length, req_waited_in});
         words_sent++;
         if (burst_left > 0) burst_left--;
         if (burst_left == 0) gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
         if (pending_words.size() > 0 && !send_hold && gap_left == 0) begin
            {req_mode, req_job_id, req_job_size, req_tape_needs, req_print_needs,
             req_run_length, req_waited_in} <= pending_words.pop_front();
            if (burst_left == 0) burst_left = $urandom_range(1, 12);
         end else begin
            req_valid <= 1'b0;
         end
      end else if (!req_valid) begin
         if (gap_left > 0) begin
            gap_left--;
         end else if (pending_words.size() > 0 && !send_hold) begin
            {req_mode, req_job_id, req_job_size, req_tape_needs, req_print_needs,
             req_run_length, req_waited_in} <= pending_words.pop_front();
            req_valid <= 1'b1;
            if (burst_left == 0) burst_left = $urandom_range(1, 12);
         end
      end
   end

   // stall the response side on its own pattern
   int stall_phase = 0;
   always @(posedge clock) begin
      stall_phase <= stall_phase + 1;
      if (reset || stall_phase % 400 < 120) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(0, 99) < 45);
   end

   // compare accepted response words with the oldest expectation
   always @(posedge clock) begin
      job_rsp_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_kind, rsp_job_out, rsp_time_now, rsp_last};
         rsp_seen++;
         if (expected_rsp.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected response word kind=%0d job=%0d time=%0d last=%0d",
                        got.kind, got.job_out, got.time_now, got.last);
         end else begin
            want = expected_rsp.pop_front();
            if (got !== want) begin
               fail_count++;
               if (fail_count <= 10)
                  $display({"mismatch: exp kind=%0d job=%0d time=%0d last=%0d,",
                            " got kind=%0d job=%0d time=%0d last=%0d"},
                           want.kind, want.job_out, want.time_now, want.last,
                           got.kind, got.job_out, got.time_now, got.last);
            end
         end
      end
   end

   // end the run when nothing has moved for too long
   int idle_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_MAX) begin
         $display("watchdog: no handshake for %0d cycles", WDOG_MAX);
         $display("tb failed");
         $finish;
      end
   end

   function automatic job_req_type mk(logic [1:0] m, logic [7:0] id, logic [7:0] sz,
                                      logic [3:0] tp, logic [3:0] pr,
                                      logic [15:0] run, logic [15:0] wt);
      return '{m, id, sz, tp, pr, run, wt};
   endfunction

   // word of a given mode with random don't-care fields
   function automatic job_req_type rand_other(logic [1:0] m);
      return mk(m, 8'($urandom), 8'($urandom), 4'($urandom), 4'($urandom),
                16'($urandom), 16'($urandom));
   endfunction

   function automatic job_req_type rand_load();
      job_req_type w;
      w = mk(hrrn_pkg::MODE_LOAD, 8'($urandom_range(0, 255)),
             ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) :
                                           8'($urandom_range(0, 40)),
             4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
             ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535)) :
                                           16'($urandom_range(0, 300)),
             16'($urandom_range(0, 65535)));
      if ($urandom_range(0, 2) != 0) begin
         w.tape_needs = 4'($urandom_range(0, 3));
         w.print_needs = 4'($urandom_range(0, 2));
      end
      return w;
   endfunction

   task automatic wait_drained();
      while (pending_words.size() > 0 || req_valid || expected_rsp.size() > 0)
         @(posedge clock);
      repeat (2 * SLOTS + 10) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [7:0] val);
      csr_write <= 1'b1; csr_index <= idx; csr_data <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         hrrn_pkg::CSR_RAM:   cap_ram = val;
         hrrn_pkg::CSR_TAPE:  cap_tape = val[3:0];
         hrrn_pkg::CSR_PRINT: cap_print = val[3:0];
         default: ;
      endcase
   endtask

   initial begin
      job_req_type w;
      int r;
      table_reset();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, every mode, zero run, nothing running/fitting
      pending_words.push_back(mk(hrrn_pkg::MODE_COMPLETE, 0, 0, 0, 0, 0, 0));
      pending_words.push_back(mk(hrrn_pkg::MODE_DISPATCH, 0, 0, 0, 0, 0, 0));
      pending_words.push_back(mk(hrrn_pkg::MODE_LOAD, 8'hFF, 8'hFF, 4'hF, 4'hF,
                                 16'hFFFF, 16'hFFFF));
      pending_words.push_back(mk(hrrn_pkg::MODE_LOAD, 8'h00, 8'd10, 4'd1, 4'd1, 16'd0, 16'd0));
      pending_words.push_back(mk(hrrn_pkg::MODE_LOAD, 8'h5A, 8'd10, 4'd1, 4'd0, 16'd4, 16'd4));
      pending_words.push_back(mk(hrrn_pkg::MODE_LOAD, 8'hA5, 8'd10, 4'd1, 4'd0, 16'd2, 16'd2));
      pending_words.push_back(mk(MODE_UNUSED, 8'hFF, 8'hFF, 4'hF, 4'hF, 16'hFFFF, 16'hFFFF));
      pending_words.push_back(mk(hrrn_pkg::MODE_DISPATCH, 0, 0, 0, 0, 0, 0));
      pending_words.push_back(mk(hrrn_pkg::MODE_DISPATCH, 0, 0, 0, 0, 0, 0));
      for (int i = 0; i < 4; i++)
         pending_words.push_back(mk(hrrn_pkg::MODE_COMPLETE, 0, 0, 0, 0, 0, 0));
      wait_drained();

      // full table, then many admissions with maximum capacity
      write_reg(hrrn_pkg::CSR_RAM, 8'hFF);
      write_reg(hrrn_pkg::CSR_TAPE, 8'h0F);
      write_reg(hrrn_pkg::CSR_PRINT, 8'h0F);
      for (int i = 0; i < SLOTS + 1; i++)
         pending_words.push_back(mk(hrrn_pkg::MODE_LOAD, 8'(i), 0, 0, 0, 16'(i + 1),
                                    16'(65535 - i)));
      pending_words.push_back(mk(hrrn_pkg::MODE_DISPATCH, 0, 0, 0, 0, 0, 0));
      for (int i = 0; i < SLOTS; i++)
         pending_words.push_back(mk(hrrn_pkg::MODE_COMPLETE, 0, 0, 0, 0, 0, 0));
      wait_drained();

      // random phases under different capacity settings
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin
               write_reg(hrrn_pkg::CSR_RAM, 0);
               write_reg(hrrn_pkg::CSR_TAPE, 0);
               write_reg(hrrn_pkg::CSR_PRINT, 0);
            end
            1: begin
               write_reg(hrrn_pkg::CSR_RAM, 64);
               write_reg(hrrn_pkg::CSR_TAPE, 4);
               write_reg(hrrn_pkg::CSR_PRINT, 2);
            end
            2: begin
               write_reg(hrrn_pkg::CSR_RAM, 255);
               write_reg(hrrn_pkg::CSR_TAPE, 15);
               write_reg(hrrn_pkg::CSR_PRINT, 15);
            end
            default: begin
               write_reg(hrrn_pkg::CSR_RAM, 8'($urandom_range(0, 255)));
               write_reg(hrrn_pkg::CSR_TAPE, 8'($urandom_range(0, 15)));
               write_reg(hrrn_pkg::CSR_PRINT, 8'($urandom_range(0, 15)));
            end
         endcase
         for (int k = 0; k < 42; k++) begin
            r = $urandom_range(0, 99);
            if (r < 45) w = rand_load();
            else if (r < 65) w = rand_other(hrrn_pkg::MODE_DISPATCH);
            else if (r < 97) w = rand_other(hrrn_pkg::MODE_COMPLETE);
            else w = rand_other(MODE_UNUSED);
            pending_words.push_back(w);
         end
         // sender waits for every response before resuming
         if (ph == 3) begin
            while (pending_words.size() > 25 || req_valid) @(posedge clock);
            send_hold = 1'b1;
            while (expected_rsp.size() > 0) @(posedge clock);
            send_hold = 1'b0;
         end
         wait_drained();
      end

      // shrink capacity while jobs run
      write_reg(hrrn_pkg::CSR_RAM, 8'hFF);
      write_reg(hrrn_pkg::CSR_TAPE, 8'h0F);
      write_reg(hrrn_pkg::CSR_PRINT, 8'h0F);
      for (int i = 0; i < 6; i++) pending_words.push_back(rand_load());
      pending_words.push_back(mk(hrrn_pkg::MODE_DISPATCH, 0, 0, 0, 0, 0, 0));
      wait_drained();
      write_reg(hrrn_pkg::CSR_RAM, 8'd1);
      write_reg(hrrn_pkg::CSR_TAPE, 8'd0);
      write_reg(hrrn_pkg::CSR_PRINT, 8'd0);
      for (int i = 0; i < 8; i++) begin
         pending_words.push_back(rand_load());
         pending_words.push_back(mk(hrrn_pkg::MODE_DISPATCH, 0, 0, 0, 0, 0, 0));
         pending_words.push_back(mk(hrrn_pkg::MODE_COMPLETE, 0, 0, 0, 0, 0, 0));
      end
      wait_drained();

      $display("run covered %0d request words, %0d response words", words_sent, rsp_seen);
      $display("  %0d dispatches, %0d completions across several capacity settings",
               n_dispatched, n_completed);
      if (fail_count == 0 && expected_rsp.size() == 0) begin
         $display("tb passed");
      end else begin
         $display("%0d mismatches, %0d words still expected", fail_count, expected_rsp.size());
         $display("tb failed");
      end
      $finish;
   end

endmodule
